// ===== src/cdt_pkg.sv =====
// shared types, constants and calendar tables for the date to ticks converter
package cdt_pkg;

   localparam int MAX_YEAR     = 9999;
   localparam int TICKS_PER_US = 10;

   localparam int YEAR_W  = 14;
   localparam int MONTH_W = 4;
   localparam int DAY_W   = 5;
   localparam int HOUR_W  = 5;
   localparam int MIN_W   = 6;
   localparam int SEC_W   = 6;
   localparam int USEC_W  = 20;
   localparam int DOY_W   = 9;
   localparam int SERIAL_W = 22;
   localparam int TICK_W  = 62;
   localparam int HMS_W   = 17;

   localparam int MAX_MONTH  = 12;
   localparam int MAX_HOUR   = 23;
   localparam int MAX_MINUTE = 59;
   localparam int MAX_SECOND = 59;
   localparam int MAX_USEC   = 999999;

   // floor(x / 100) == (x * RECIP_100) >> RECIP_SHIFT for every 14-bit x
   localparam int RECIP_100   = 5243;
   localparam int RECIP_SHIFT = 19;

   localparam int DAYS_PER_YEAR = 365;
   localparam int SEC_PER_DAY   = 86400;
   localparam int US_PER_SEC    = 1000000;

   typedef struct packed {
      logic                  ok;
      logic                  leap;
      logic [DOY_W-1:0]      doy;
      logic [SERIAL_W-1:0]   serial;
      logic [HMS_W-1:0]      hms;
      logic [USEC_W-1:0]     us;
   } cdt_day_type;

   // days before the first of the month
   function automatic logic [DOY_W-1:0] month_start(input logic leap,
                                                    input logic [MONTH_W-1:0] mo);
      logic [DOY_W-1:0] base;
      case (mo)
         4'd1:    base = 9'd0;
         4'd2:    base = 9'd31;
         4'd3:    base = 9'd59;
         4'd4:    base = 9'd90;
         4'd5:    base = 9'd120;
         4'd6:    base = 9'd151;
         4'd7:    base = 9'd181;
         4'd8:    base = 9'd212;
         4'd9:    base = 9'd243;
         4'd10:   base = 9'd273;
         4'd11:   base = 9'd304;
         4'd12:   base = 9'd334;
         default: base = 9'd0;
      endcase
      if (leap && mo > 4'd2) begin
         base = base + 9'd1;
      end
      return base;
   endfunction

   function automatic logic [DAY_W-1:0] month_len(input logic leap,
                                                  input logic [MONTH_W-1:0] mo);
      logic [DAY_W-1:0] len;
      case (mo) inside
         4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
         4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
         4'd2:    len = leap ? 5'd29 : 5'd28;
         default: len = 5'd0;
      endcase
      return len;
   endfunction

endpackage

// ===== src/calendar_date_to_ticks.sv =====
// civil date and time to serial day and tick count, eight stage pipeline
//
//  channel | direction | handshake            | payload
//  req     | in        | req_valid/req_ready  | year month day hour minute second microsecond
//  rsp     | out       | rsp_valid/rsp_ready  | valid_res leap day_of_year serial_day tick_count
//
// one request enters every cycle unless a result waits unread at the output stage
// the eight stages advance together and hold as a whole while a result waits
// unread, so req_ready follows rsp_ready whenever the output stage is full
// the depth is set by the reciprocal divides, the calendar lookup and the
// split multiply by one million
// reset clears only the stage valid bits
module calendar_date_to_ticks #(
   parameter int MAX_YEAR     = cdt_pkg::MAX_YEAR,
   parameter int TICKS_PER_US = cdt_pkg::TICKS_PER_US
) (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_valid,
   output logic                            req_ready,
   input  logic [cdt_pkg::YEAR_W-1:0]      req_year,
   input  logic [cdt_pkg::MONTH_W-1:0]     req_month,
   input  logic [cdt_pkg::DAY_W-1:0]       req_day,
   input  logic [cdt_pkg::HOUR_W-1:0]      req_hour,
   input  logic [cdt_pkg::MIN_W-1:0]       req_minute,
   input  logic [cdt_pkg::SEC_W-1:0]       req_second,
   input  logic [cdt_pkg::USEC_W-1:0]      req_microsecond,
   output logic                            rsp_valid,
   input  logic                            rsp_ready,
   output logic                            rsp_valid_res,
   output logic                            rsp_leap,
   output logic [cdt_pkg::DOY_W-1:0]       rsp_day_of_year,
   output logic [cdt_pkg::SERIAL_W-1:0]    rsp_serial_day,
   output logic [cdt_pkg::TICK_W-1:0]      rsp_tick_count
);

   localparam int STAGES = 8;
   localparam int DSEC_W = 39;
   localparam int LO_W   = 40;
   localparam int HI_W   = 39;
   localparam int USUM_W = 59;
   localparam int SPLIT  = 20;

   logic              en;
   logic [STAGES-1:0] v_ff, v_in;

   assign en        = rsp_ready || !v_ff[STAGES-1];
   assign req_ready = en;
   assign v_in      = {v_ff[STAGES-2:0], req_valid};

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff <= '0;
      end else if (en) begin
         v_ff <= v_in;
      end
   end

   // stage 1: request capture
   logic [cdt_pkg::YEAR_W-1:0]  y1_ff;
   logic [cdt_pkg::MONTH_W-1:0] mo1_ff;
   logic [cdt_pkg::DAY_W-1:0]   d1_ff;
   logic [cdt_pkg::HOUR_W-1:0]  h1_ff;
   logic [cdt_pkg::MIN_W-1:0]   mi1_ff;
   logic [cdt_pkg::SEC_W-1:0]   s1_ff;
   logic [cdt_pkg::USEC_W-1:0]  us1_ff;

   always_ff @(posedge clock) begin
      if (en) begin
         y1_ff  <= req_year;
         mo1_ff <= req_month;
         d1_ff  <= req_day;
         h1_ff  <= req_hour;
         mi1_ff <= req_minute;
         s1_ff  <= req_second;
         us1_ff <= req_microsecond;
      end
   end

   // stages 2 to 4
   cdt_pkg::cdt_day_type day4;

   cdt_date #(
      .MAX_YEAR    (MAX_YEAR)
   ) u_date (
      .clock       (clock),
      .en          (en),
      .year        (y1_ff),
      .month       (mo1_ff),
      .day         (d1_ff),
      .hour        (h1_ff),
      .minute      (mi1_ff),
      .second      (s1_ff),
      .microsecond (us1_ff),
      .day_out     (day4)
   );

   // stage 5: seconds since epoch
   cdt_pkg::cdt_day_type day5_ff, day6_ff, day7_ff;
   logic [DSEC_W-1:0]    dsec5_ff, dsec5_in;

   assign dsec5_in = DSEC_W'(day4.serial) * DSEC_W'(cdt_pkg::SEC_PER_DAY)
                   + DSEC_W'(day4.hms);

   always_ff @(posedge clock) begin
      if (en) begin
         day5_ff  <= day4;
         dsec5_ff <= dsec5_in;
      end
   end

   // stage 6: times one million as two partial products
   logic [LO_W-1:0] lo6_ff, lo6_in;
   logic [HI_W-1:0] hi6_ff, hi6_in;

   assign lo6_in = LO_W'(dsec5_ff[SPLIT-1:0]) * LO_W'(cdt_pkg::US_PER_SEC);
   assign hi6_in = HI_W'(dsec5_ff[DSEC_W-1:SPLIT]) * HI_W'(cdt_pkg::US_PER_SEC);

   always_ff @(posedge clock) begin
      if (en) begin
         day6_ff <= day5_ff;
         lo6_ff  <= lo6_in;
         hi6_ff  <= hi6_in;
      end
   end

   // stage 7: recombine and add microseconds
   logic [USUM_W-1:0] usum7_ff, usum7_in;

   assign usum7_in = {hi6_ff, {SPLIT{1'b0}}} + USUM_W'(lo6_ff) + USUM_W'(day6_ff.us);

   always_ff @(posedge clock) begin
      if (en) begin
         day7_ff  <= day6_ff;
         usum7_ff <= usum7_in;
      end
   end

   // stage 8: scale to ticks, zero the result of a rejected request
   logic                          ok8_ff, leap8_ff;
   logic [cdt_pkg::DOY_W-1:0]     doy8_ff;
   logic [cdt_pkg::SERIAL_W-1:0]  serial8_ff;
   logic [cdt_pkg::TICK_W-1:0]    tick8_ff, tick8_in;

   assign tick8_in = cdt_pkg::TICK_W'(usum7_ff) * cdt_pkg::TICK_W'(TICKS_PER_US);

   always_ff @(posedge clock) begin
      if (en) begin
         ok8_ff     <= day7_ff.ok;
         leap8_ff   <= day7_ff.ok && day7_ff.leap;
         doy8_ff    <= day7_ff.ok ? day7_ff.doy : '0;
         serial8_ff <= day7_ff.ok ? day7_ff.serial : '0;
         tick8_ff   <= day7_ff.ok ? tick8_in : '0;
      end
   end

   assign rsp_valid       = v_ff[STAGES-1];
   assign rsp_valid_res   = ok8_ff;
   assign rsp_leap        = leap8_ff;
   assign rsp_day_of_year = doy8_ff;
   assign rsp_serial_day  = serial8_ff;
   assign rsp_tick_count  = tick8_ff;

`ifndef SYNTHESIS
   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_valid_res |-> !rsp_leap && rsp_day_of_year == '0
         && rsp_serial_day == '0 && rsp_tick_count == '0)
      else $error("rejected request gives a nonzero result");

   a_doy_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_valid_res |-> rsp_day_of_year != '0
         && (rsp_day_of_year <= 9'd365 || (rsp_leap && rsp_day_of_year == 9'd366)))
      else $error("day of year out of range for the leap flag");

   a_reset_empty: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid right after reset");

   a_stall_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && !req_ready || rsp_ready)
      else $error("pipeline advanced while the output stalled");
`endif

endmodule

// ===== src/cdt_date.sv =====
// date check, leap year and serial day stages (three register stages)
module cdt_date #(
   parameter int MAX_YEAR = cdt_pkg::MAX_YEAR
) (
   input  logic                            clock,
   input  logic                            en,
   input  logic [cdt_pkg::YEAR_W-1:0]      year,
   input  logic [cdt_pkg::MONTH_W-1:0]     month,
   input  logic [cdt_pkg::DAY_W-1:0]       day,
   input  logic [cdt_pkg::HOUR_W-1:0]      hour,
   input  logic [cdt_pkg::MIN_W-1:0]       minute,
   input  logic [cdt_pkg::SEC_W-1:0]       second,
   input  logic [cdt_pkg::USEC_W-1:0]      microsecond,
   output cdt_pkg::cdt_day_type            day_out
);

   localparam int PROD_W = 27;
   localparam int QUOT_W = PROD_W - cdt_pkg::RECIP_SHIFT;
   localparam int HM_W   = 11;
   localparam int BASE_W = 23;

   // stage 2: reciprocal divides, range checks
   logic [cdt_pkg::YEAR_W-1:0]  y2_ff, py2_ff;
   logic [QUOT_W-1:0]           qy2_ff, qpy2_ff;
   logic                        rng2_ff;
   logic [cdt_pkg::MONTH_W-1:0] mo2_ff;
   logic [cdt_pkg::DAY_W-1:0]   d2_ff;
   logic [HM_W-1:0]             hm2_ff;
   logic [cdt_pkg::SEC_W-1:0]   s2_ff;
   logic [cdt_pkg::USEC_W-1:0]  us2_ff;

   logic [cdt_pkg::YEAR_W-1:0]  py2_in;
   logic [PROD_W-1:0]           qy_prod, qpy_prod;
   logic                        rng2_in;
   logic [HM_W-1:0]             hm2_in;

   always_comb begin
      py2_in   = year - cdt_pkg::YEAR_W'(1);
      qy_prod  = PROD_W'(year) * PROD_W'(cdt_pkg::RECIP_100);
      qpy_prod = PROD_W'(py2_in) * PROD_W'(cdt_pkg::RECIP_100);
      rng2_in  = (year != '0) && (year <= cdt_pkg::YEAR_W'(MAX_YEAR))
               && (month != '0) && (month <= cdt_pkg::MONTH_W'(cdt_pkg::MAX_MONTH))
               && (hour <= cdt_pkg::HOUR_W'(cdt_pkg::MAX_HOUR))
               && (minute <= cdt_pkg::MIN_W'(cdt_pkg::MAX_MINUTE))
               && (second <= cdt_pkg::SEC_W'(cdt_pkg::MAX_SECOND))
               && (microsecond <= cdt_pkg::USEC_W'(cdt_pkg::MAX_USEC));
      hm2_in   = HM_W'(hour) * HM_W'(60) + HM_W'(minute);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         y2_ff   <= year;
         py2_ff  <= py2_in;
         qy2_ff  <= qy_prod[PROD_W-1:cdt_pkg::RECIP_SHIFT];
         qpy2_ff <= qpy_prod[PROD_W-1:cdt_pkg::RECIP_SHIFT];
         rng2_ff <= rng2_in;
         mo2_ff  <= month;
         d2_ff   <= day;
         hm2_ff  <= hm2_in;
         s2_ff   <= second;
         us2_ff  <= microsecond;
      end
   end

   // stage 3: leap year, day of year, month length check
   logic                         ok3_ff, leap3_ff;
   logic [cdt_pkg::DOY_W-1:0]    doy3_ff;
   logic [BASE_W-1:0]            base3_ff;
   logic [QUOT_W-1:0]            qpy3_ff;
   logic [cdt_pkg::HMS_W-1:0]    hms3_ff;
   logic [cdt_pkg::USEC_W-1:0]   us3_ff;

   logic                         cent3, leap3_in, ok3_in;
   logic [cdt_pkg::DOY_W-1:0]    doy3_in;
   logic [BASE_W-1:0]            base3_in;
   logic [cdt_pkg::HMS_W-1:0]    hms3_in;

   always_comb begin
      // year divisible by 100
      cent3    = ((cdt_pkg::YEAR_W+1)'(qy2_ff) * (cdt_pkg::YEAR_W+1)'(100))
               == {1'b0, y2_ff};
      leap3_in = (y2_ff[1:0] == 2'b00) && (!cent3 || (qy2_ff[1:0] == 2'b00));
      doy3_in  = cdt_pkg::DOY_W'(d2_ff) + cdt_pkg::month_start(leap3_in, mo2_ff);
      ok3_in   = rng2_ff && (d2_ff != '0)
               && (d2_ff <= cdt_pkg::month_len(leap3_in, mo2_ff));
      base3_in = BASE_W'(py2_ff) * BASE_W'(cdt_pkg::DAYS_PER_YEAR)
               + BASE_W'(py2_ff >> 2);
      hms3_in  = cdt_pkg::HMS_W'(hm2_ff) * cdt_pkg::HMS_W'(60)
               + cdt_pkg::HMS_W'(s2_ff);
   end

   always_ff @(posedge clock) begin
      if (en) begin
         ok3_ff   <= ok3_in;
         leap3_ff <= leap3_in;
         doy3_ff  <= doy3_in;
         base3_ff <= base3_in;
         qpy3_ff  <= qpy2_ff;
         hms3_ff  <= hms3_in;
         us3_ff   <= us2_ff;
      end
   end

   // stage 4: serial day
   cdt_pkg::cdt_day_type day4_ff, day4_in;
   logic [BASE_W-1:0]    serial_sum;

   always_comb begin
      serial_sum     = base3_ff + BASE_W'(doy3_ff) - BASE_W'(1) - BASE_W'(qpy3_ff)
                     + BASE_W'(qpy3_ff >> 2);
      day4_in.ok     = ok3_ff;
      day4_in.leap   = leap3_ff;
      day4_in.doy    = doy3_ff;
      day4_in.serial = serial_sum[cdt_pkg::SERIAL_W-1:0];
      day4_in.hms    = hms3_ff;
      day4_in.us     = us3_ff;
   end

   always_ff @(posedge clock) begin
      if (en) begin
         day4_ff <= day4_in;
      end
   end

   assign day_out = day4_ff;

endmodule
